[sv/ttu_pkg.sv]
// ----------------------------------------------------------------------------
// ttu_pkg
// Shared types and constants for the triangle tangent unit.
// ----------------------------------------------------------------------------
package ttu_pkg;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned TEX_W  = 16;
  localparam int unsigned OUT_W  = 16;
  localparam int unsigned TAN_W  = 52;  // exact raw tangent component width
  localparam int unsigned MAG_W  = 30;  // normalized magnitude width
  localparam int unsigned SUM_W  = 62;  // sum of three squares
  localparam int unsigned LEN_W  = 31;
  localparam int unsigned NUM_W  = 45;  // mag * 2^14 + len/2
  localparam logic [OUT_W-1:0] ONE_Q14 = 16'd16384;

  localparam logic [1:0] CORNER_LAST = 2'd2;
  localparam logic [1:0] CORNER_BAD  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_DET,
    ST_TAN,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } ttu_state_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic start;      // latch corner 2 and start
    logic do_delta;
    logic do_det;
    logic do_tan;
    logic do_norm;
    logic do_sq;
    logic do_sqrt;
    logic do_div;
    logic [1:0] idx;  // component index
    logic [5:0] step; // iteration counter
  } ttu_ctrl_t;

  typedef struct packed {
    logic degen;      // det or tangent zero
    logic norm_done;
  } ttu_stat_t;

endpackage

[sv/ttu_datapath.sv]
// ----------------------------------------------------------------------------
// ttu_datapath
// Held corners and the shared multiply / sqrt / divide datapath.
// ----------------------------------------------------------------------------
module ttu_datapath (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic                          wr_slot,
  input  logic signed [ttu_pkg::POS_W-1:0] pos_x,
  input  logic signed [ttu_pkg::POS_W-1:0] pos_y,
  input  logic signed [ttu_pkg::POS_W-1:0] pos_z,
  input  logic signed [ttu_pkg::TEX_W-1:0] tex_u,
  input  logic signed [ttu_pkg::TEX_W-1:0] tex_v,
  input  ttu_pkg::ttu_ctrl_t            ctrl,
  output ttu_pkg::ttu_stat_t            stat,
  output logic signed [ttu_pkg::OUT_W-1:0] res_x,
  output logic signed [ttu_pkg::OUT_W-1:0] res_y,
  output logic signed [ttu_pkg::OUT_W-1:0] res_z
);
  import ttu_pkg::*;

  logic signed [POS_W-1:0] hp_r [6];
  logic signed [TEX_W-1:0] ht_r [4];
  logic signed [POS_W-1:0] p2_r [3];
  logic signed [TEX_W:0]   du1_r, dv1_r, du2_r, dv2_r;
  logic signed [POS_W:0]   dp1_r [3];
  logic signed [POS_W:0]   dp2_r [3];
  logic signed [2*TEX_W+2:0] det_r;
  logic [TAN_W-1:0]        mag_r [3];
  logic                    neg_r [3];
  logic [SUM_W-1:0]        sum_r, rem_r;
  logic [LEN_W-1:0]        len_r;
  logic [NUM_W-1:0]        num_r;
  logic [OUT_W-1:0]        q_r;
  logic signed [OUT_W-1:0] res_r [3];

  logic signed [2*TEX_W+1:0] pa, pb;
  logic signed [TAN_W-1:0]   ta, tb, tt;
  logic [TAN_W-1:0]          mx;
  logic [MAG_W-1:0]          mc;
  logic [SUM_W-1:0]          sq;
  logic [SUM_W-1:0]          trial;
  logic [LEN_W:0]            lt;
  logic [NUM_W-1:0]          dsub;
  logic [OUT_W-1:0]          qr;
  logic [1:0]                i;
  logic [2:0]                hbase;

  assign i     = ctrl.idx;
  assign hbase = wr_slot ? 3'd3 : 3'd0;

  // shared multiplies: one component per cycle
  always_comb begin
    pa = du1_r * dv2_r;
    pb = du2_r * dv1_r;
    ta = TAN_W'(dv2_r) * TAN_W'(dp1_r[i]);
    tb = TAN_W'(dv1_r) * TAN_W'(dp2_r[i]);
    tt = ta - tb;
    if (det_r < 0) tt = -tt;
    mx = mag_r[0];
    if (mag_r[1] > mx) mx = mag_r[1];
    if (mag_r[2] > mx) mx = mag_r[2];
    mc = mag_r[i][MAG_W-1:0];
    sq = SUM_W'(mc) * SUM_W'(mc);
    // restoring sqrt: one result bit per step
    trial = SUM_W'({len_r, 2'b01}) << (2 * (LEN_W - 1 - ctrl.step[4:0]));
    lt = {len_r, 1'b1};
    dsub = NUM_W'(len_r) << (OUT_W - 1 - ctrl.step[3:0]);
    qr = q_r;
    if (q_r > ONE_Q14) qr = ONE_Q14;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hp_r[hbase]        <= pos_x;
      hp_r[hbase + 3'd1] <= pos_y;
      hp_r[hbase + 3'd2] <= pos_z;
      ht_r[{wr_slot, 1'b0}]     <= tex_u;
      ht_r[{wr_slot, 1'b1}]     <= tex_v;
    end
    if (ctrl.start) begin
      p2_r[0] <= pos_x; p2_r[1] <= pos_y; p2_r[2] <= pos_z;
      du2_r <= (TEX_W+1)'(tex_u) - (TEX_W+1)'(ht_r[0]);
      dv2_r <= (TEX_W+1)'(tex_v) - (TEX_W+1)'(ht_r[1]);
      du1_r <= (TEX_W+1)'(ht_r[2]) - (TEX_W+1)'(ht_r[0]);
      dv1_r <= (TEX_W+1)'(ht_r[3]) - (TEX_W+1)'(ht_r[1]);
    end
    if (ctrl.do_delta) begin
      for (int k = 0; k < 3; k++) begin
        dp1_r[k] <= (POS_W+1)'(hp_r[3+k]) - (POS_W+1)'(hp_r[k]);
        dp2_r[k] <= (POS_W+1)'(p2_r[k]) - (POS_W+1)'(hp_r[k]);
      end
    end
    if (ctrl.do_det) det_r <= (2*TEX_W+3)'(pa) - (2*TEX_W+3)'(pb);
    if (ctrl.do_tan) begin
      neg_r[i] <= tt < 0;
      mag_r[i] <= (tt < 0) ? TAN_W'(-tt) : TAN_W'(tt);
    end
    if (ctrl.do_norm) begin
      rem_r <= '0;
      len_r <= '0;
      for (int k = 0; k < 3; k++) begin
        if (mx >= (TAN_W'(1) << MAG_W)) mag_r[k] <= mag_r[k] >> 1;
        else if (mx < (TAN_W'(1) << (MAG_W-1))) mag_r[k] <= mag_r[k] << 1;
      end
    end
    if (ctrl.do_sq) sum_r <= sum_r + sq;
    if (ctrl.do_sqrt) begin
      if (ctrl.step == 6'd0) begin
        if ((sum_r >> (2*(LEN_W-1))) >= SUM_W'(1)) begin
          rem_r <= sum_r - (SUM_W'(1) << (2*(LEN_W-1)));
          len_r <= LEN_W'(1);
        end else begin
          rem_r <= sum_r;
          len_r <= '0;
        end
      end else if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        len_r <= lt[LEN_W-1:0];
      end else begin
        len_r <= {len_r[LEN_W-2:0], 1'b0};
      end
    end
    if (ctrl.do_div) begin
      if (ctrl.step == 6'd0) begin
        num_r <= (NUM_W'(mag_r[i][MAG_W-1:0]) << 14) + NUM_W'(len_r >> 1);
        q_r   <= '0;
      end else if (num_r >= dsub) begin
        num_r <= num_r - dsub;
        q_r   <= {q_r[OUT_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[OUT_W-2:0], 1'b0};
      end
    end
    if (ctrl.do_sq && ctrl.step == 6'd63) begin
      // finalize the quotient of the current component
      res_r[i] <= neg_r[i] ? -$signed(qr) : $signed(qr);
    end
    if (ctrl.start) begin
      sum_r <= '0;
      res_r[0] <= '0; res_r[1] <= '0; res_r[2] <= '0;
    end
  end

  always_comb begin
    stat.degen     = (det_r == '0) || (mx == '0);
    stat.norm_done = (mx < (TAN_W'(1) << MAG_W)) && (mx >= (TAN_W'(1) << (MAG_W-1)));
  end

  assign res_x = stat.degen ? '0 : res_r[0];
  assign res_y = stat.degen ? '0 : res_r[1];
  assign res_z = stat.degen ? '0 : res_r[2];

endmodule

[sv/ttu_seq.sv]
// ----------------------------------------------------------------------------
// ttu_seq
// Sequencer stepping the shared datapath through one triangle.
// ----------------------------------------------------------------------------
module ttu_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  ttu_pkg::ttu_stat_t stat,
  input  logic               out_stall,
  output ttu_pkg::ttu_ctrl_t ctrl,
  output logic               busy,
  output logic               out_valid
);
  import ttu_pkg::*;

  ttu_state_t state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [5:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE:  if (go) state_nxt = ST_DELTA;
      ST_DELTA: state_nxt = ST_DET;
      ST_DET: begin
        state_nxt = ST_TAN;
        idx_nxt   = '0;
      end
      ST_TAN: begin
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd2) begin
          idx_nxt   = '0;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (stat.degen) state_nxt = ST_DONE;
        else if (stat.norm_done) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd2) begin
          idx_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd30) begin
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd15) begin
          step_nxt = 6'd63;
          state_nxt = ST_DIV;
        end
        if (step_r == 6'd63) begin
          step_nxt = '0;
          idx_nxt  = idx_r + 2'd1;
          if (idx_r == 2'd2) begin
            idx_nxt   = '0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE:  if (!out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.idx      = idx_r;
    ctrl.step     = step_r;
    ctrl.start    = (state_r == ST_IDLE) && go;
    ctrl.do_delta = (state_r == ST_DELTA);
    ctrl.do_det   = (state_r == ST_DET);
    ctrl.do_tan   = (state_r == ST_TAN);
    ctrl.do_norm  = (state_r == ST_NORM) && !stat.norm_done && !stat.degen;
    ctrl.do_sq    = (state_r == ST_SQ) ||
                    ((state_r == ST_DIV) && (step_r == 6'd63));
    ctrl.do_sqrt  = (state_r == ST_SQRT);
    ctrl.do_div   = (state_r == ST_DIV) && (step_r != 6'd63);
    busy          = (state_r != ST_IDLE);
    out_valid     = (state_r == ST_DONE);
  end

endmodule

[sv/triangle_tangent_unit.sv]
// ----------------------------------------------------------------------------
// triangle_tangent_unit
// Per-triangle unit tangent from three streamed corners.
// ----------------------------------------------------------------------------
// Feed one corner per transfer on the in_ channel. Corners 0 and 1 are held;
// corner 3 is dropped. Corner 2 starts the shared sequencer: delta,
// determinant, three tangent multiplies, one normalize check plus up to 29
// one-bit shifts, three squares, a 31-step bit-serial square root and three
// restoring divides. When out_valid rises depends on the shift count and the
// serial sqrt and divide loops; a degenerate triangle goes from the normalize
// check straight to the result. Without stalls the sequencer then returns to
// idle and the next corner can transfer.
// While busy, in_stall stays high.
// The result sits on the out_ ports with out_valid high until a transfer;
// out_stall holds it and the block. Reset (rst_n low, synchronous) returns
// the sequencer to idle; held corners are undefined until written.
// ----------------------------------------------------------------------------
module triangle_tangent_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_corner,
  input  logic signed [ttu_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [ttu_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [ttu_pkg::POS_W-1:0]  in_pos_z,
  input  logic signed [ttu_pkg::TEX_W-1:0]  in_tex_u,
  input  logic signed [ttu_pkg::TEX_W-1:0]  in_tex_v,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ttu_pkg::OUT_W-1:0]  out_tangent_x,
  output logic signed [ttu_pkg::OUT_W-1:0]  out_tangent_y,
  output logic signed [ttu_pkg::OUT_W-1:0]  out_tangent_z,
  output logic                              out_degenerate
);
  import ttu_pkg::*;

  ttu_ctrl_t ctrl;
  ttu_stat_t stat;
  logic      busy, acc, go;

  assign in_stall = busy;
  assign acc      = in_valid && !busy;
  assign go       = acc && (in_corner == CORNER_LAST);

  ttu_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .stat      (stat),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ttu_datapath u_dp (
    .clk     (clk),
    .wr_en   (acc && (in_corner != CORNER_LAST) && (in_corner != CORNER_BAD)),
    .wr_slot (in_corner[0]),
    .pos_x   (in_pos_x),
    .pos_y   (in_pos_y),
    .pos_z   (in_pos_z),
    .tex_u   (in_tex_u),
    .tex_v   (in_tex_v),
    .ctrl    (ctrl),
    .stat    (stat),
    .res_x   (out_tangent_x),
    .res_y   (out_tangent_y),
    .res_z   (out_tangent_z)
  );

  assign out_degenerate = stat.degen;

endmodule
